[rtl/sdkr_pkg.sv]
package sdkr_pkg;

  localparam int MAX_DIGITS = 64;
  localparam int DIGIT_W    = 4;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int TDATA_W    = 8;
  localparam int REM_W      = 7;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = DIGIT_W'(9);
  localparam logic [DIGIT_W-1:0] DIGIT_ZERO = DIGIT_W'(0);

  // Chain operation: DOWN shifts toward the bottom end (push / drain),
  // UP shifts toward cell 0 (pop).
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DOWN,
    OP_UP
  } stack_op_t;

  typedef struct packed {
    stack_op_t          op;
    logic [DIGIT_W-1:0] digit;
  } stack_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_TRIM,
    ST_ALIGN,
    ST_EMIT,
    ST_EMPTY
  } state_t;

endpackage

[rtl/smallest_digits_after_k_removals_core.sv]
// Smallest number after removing k digits, monotonic stack.
//
// in_*  : one decimal digit per transaction, most significant first.
//         in_tdata[3:0] = digit (values above 9 are treated as 9),
//         in_tlast = final digit of the number.
// cfg_* : removals count, written while idle; sampled at the first digit
//         of each number.
// out_* : result digits, most significant first, only after the final
//         input digit. out_tlast marks the final result digit, out_tuser
//         flags that digits were dropped on a full stack.
// Rate: each input digit pops larger entries 1 per cycle, then is pushed,
// before the next is taken. After the final digit, leftover removals pop
// 1 per cycle, then the stack shifts into place and streams out one digit
// per cycle. The pop/push step on the top of the cell chain sets the per-digit cost.
// The output register lets the last result wait while the next number
// starts; a stalled out_tready freezes the drain in place.
// Reset (rst_n low, synchronous) clears control, the removals register and
// the output valid; stack cells hold no reset value.
module smallest_digits_after_k_removals_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sdkr_pkg::TDATA_W-1:0] in_tdata,   // [3:0] digit
  input  logic                         in_tlast,   // last_digit
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sdkr_pkg::TDATA_W-1:0] out_tdata,  // [3:0] out_digit
  output logic                         out_tlast,  // out_last
  output logic                         out_tuser,  // overflowed
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sdkr_pkg::REM_W-1:0]   cfg_data    // removals
);
  import sdkr_pkg::*;

  state_t             state_r, state_nxt;
  logic [REM_W-1:0]   removals_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               ovf_r, ovf_nxt;
  logic               first_r, first_nxt;
  logic [DIGIT_W-1:0] dig_r, dig_nxt;
  logic               last_r, last_nxt;
  logic [CNT_W-1:0]   align_r, align_nxt;
  logic [CNT_W-1:0]   emit_r, emit_nxt;

  logic               out_valid_r;
  logic [DIGIT_W-1:0] out_digit_r, out_digit_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ovf_r;
  logic               out_load;
  logic               can_load;
  logic               can_pop;

  stack_ctl_t         ctl;
  logic [DIGIT_W-1:0] top_digit;
  logic [DIGIT_W-1:0] bottom_digit;
  logic [DIGIT_W-1:0] in_digit_sat;

  sdkr_stack u_stack (
    .clk          (clk),
    .ctl          (ctl),
    .top_digit    (top_digit),
    .bottom_digit (bottom_digit)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);

  assign in_digit_sat = (in_tdata[DIGIT_W-1:0] > DIGIT_MAX) ? DIGIT_MAX
                                                            : in_tdata[DIGIT_W-1:0];
  assign can_load = !out_valid_r || out_tready;
  assign can_pop  = (count_r != '0) && (rem_r != '0);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    ovf_nxt       = ovf_r;
    first_nxt     = first_r;
    dig_nxt       = dig_r;
    last_nxt      = last_r;
    align_nxt     = align_r;
    emit_nxt      = emit_r;
    ctl.op        = OP_HOLD;
    ctl.digit     = dig_r;
    out_load      = 1'b0;
    out_digit_nxt = bottom_digit;
    out_last_nxt  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          dig_nxt  = in_digit_sat;
          last_nxt = in_tlast;
          if (first_r) begin
            rem_nxt   = removals_r;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            first_nxt = 1'b0;
          end
          state_nxt = ST_POP;
        end
      end

      ST_POP: begin
        if (can_pop && (top_digit > dig_r)) begin
          ctl.op    = OP_UP;
          count_nxt = count_r - CNT_W'(1);
          rem_nxt   = rem_r - REM_W'(1);
        end else begin
          // a zero on an empty stack would be a leading zero
          if ((count_r != '0) || (dig_r != DIGIT_ZERO)) begin
            if (count_r < CNT_W'(MAX_DIGITS)) begin
              ctl.op    = OP_DOWN;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          state_nxt = last_r ? ST_TRIM : ST_IDLE;
        end
      end

      ST_TRIM: begin
        if (can_pop) begin
          ctl.op    = OP_UP;
          count_nxt = count_r - CNT_W'(1);
          rem_nxt   = rem_r - REM_W'(1);
        end else if (count_r == '0) begin
          state_nxt = ST_EMPTY;
        end else begin
          align_nxt = CNT_W'(MAX_DIGITS) - count_r;
          emit_nxt  = count_r;
          state_nxt = (count_r == CNT_W'(MAX_DIGITS)) ? ST_EMIT : ST_ALIGN;
        end
      end

      ST_ALIGN: begin
        // slide the bottom entry down to the chain exit
        ctl.op    = OP_DOWN;
        align_nxt = align_r - CNT_W'(1);
        if (align_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (can_load) begin
          out_load      = 1'b1;
          out_digit_nxt = bottom_digit;
          out_last_nxt  = (emit_r == CNT_W'(1));
          ctl.op        = OP_DOWN;
          emit_nxt      = emit_r - CNT_W'(1);
          if (emit_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
            first_nxt = 1'b1;
            count_nxt = '0;
          end
        end
      end

      ST_EMPTY: begin
        if (can_load) begin
          out_load      = 1'b1;
          out_digit_nxt = DIGIT_ZERO;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
          first_nxt     = 1'b1;
          count_nxt     = '0;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      removals_r  <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      ovf_r       <= 1'b0;
      first_r     <= 1'b1;
      align_r     <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      ovf_r   <= ovf_nxt;
      first_r <= first_nxt;
      align_r <= align_nxt;
      emit_r  <= emit_nxt;
      if (cfg_valid && cfg_ready) begin
        removals_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    last_r <= last_nxt;
    if (out_load) begin
      out_digit_r <= out_digit_nxt;
      out_last_r  <= out_last_nxt;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-DIGIT_W){1'b0}}, out_digit_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_DIGITS))
    else $error("stack count above depth");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (emit_r != '0))
    else $error("emit state with nothing left to emit");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (state_r == ST_IDLE) && first_r)
    else $error("final result digit did not close the number");

  a_rem_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> (rem_r <= $past(rem_r)))
    else $error("removal budget grew inside a number");

  a_fresh_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && first_r) |-> (count_r == '0))
    else $error("stack not empty at number start");
`endif

endmodule

[rtl/sdkr_cell.sv]
module sdkr_cell (
  input  logic                            clk,
  input  sdkr_pkg::stack_op_t             op,
  input  logic [sdkr_pkg::DIGIT_W-1:0]    from_above,
  input  logic [sdkr_pkg::DIGIT_W-1:0]    from_below,
  output logic [sdkr_pkg::DIGIT_W-1:0]    digit
);
  import sdkr_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;

  always_comb begin
    unique case (op)
      OP_DOWN: digit_nxt = from_above;
      OP_UP:   digit_nxt = from_below;
      default: digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

[rtl/sdkr_stack.sv]
module sdkr_stack (
  input  logic                            clk,
  input  sdkr_pkg::stack_ctl_t            ctl,
  output logic [sdkr_pkg::DIGIT_W-1:0]    top_digit,
  output logic [sdkr_pkg::DIGIT_W-1:0]    bottom_digit
);
  import sdkr_pkg::*;

  logic [DIGIT_W-1:0] cell_q [MAX_DIGITS];

  // Cell 0 is the stack top; the last cell is where drained digits exit.
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    logic [DIGIT_W-1:0] above;
    logic [DIGIT_W-1:0] below;

    if (i == 0) begin : g_first
      assign above = ctl.digit;
    end else begin : g_mid_a
      assign above = cell_q[i-1];
    end

    if (i == MAX_DIGITS - 1) begin : g_last
      assign below = cell_q[i];
    end else begin : g_mid_b
      assign below = cell_q[i+1];
    end

    sdkr_cell u_cell (
      .clk        (clk),
      .op         (ctl.op),
      .from_above (above),
      .from_below (below),
      .digit      (cell_q[i])
    );
  end

  assign top_digit    = cell_q[0];
  assign bottom_digit = cell_q[MAX_DIGITS-1];

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

typedef struct packed {
  logic [sdkr_pkg::DIGIT_W-1:0] digit;
  logic                         last;
  logic                         ovf;
} result_digit_t;

// Tracks the trimmed number for the digit stream and checks the result stream.
class trimmed_number_board;
  logic [sdkr_pkg::DIGIT_W-1:0] kept[$];   // monotonic stack, bottom at index 0
  logic [sdkr_pkg::REM_W-1:0]   removals;  // copy of the removals register
  int unsigned                  left;      // removals still allowed this number
  bit                           dropped;   // a digit met a full stack
  bit                           fresh;     // next digit opens a number
  result_digit_t                due[$];
  int unsigned                  errors;

  function new();
    removals = '0;
    left     = 0;
    dropped  = 1'b0;
    fresh    = 1'b1;
    errors   = 0;
  endfunction

  function void set_removals(input logic [sdkr_pkg::REM_W-1:0] v);
    removals = v;
  endfunction

  function int pending();
    return due.size();
  endfunction

  function void note_digit(input logic [sdkr_pkg::DIGIT_W-1:0] raw, input logic last);
    logic [sdkr_pkg::DIGIT_W-1:0] d;
    result_digit_t                r;
    d = (raw > sdkr_pkg::DIGIT_MAX) ? sdkr_pkg::DIGIT_MAX : raw;
    if (fresh) begin
      kept.delete();
      left    = removals;
      dropped = 1'b0;
      fresh   = 1'b0;
    end
    while (kept.size() > 0 && left > 0 && kept[kept.size()-1] > d) begin
      void'(kept.pop_back());
      left--;
    end
    // a zero on an empty stack would be a leading zero
    if (kept.size() > 0 || d != sdkr_pkg::DIGIT_ZERO) begin
      if (kept.size() < sdkr_pkg::MAX_DIGITS) kept.push_back(d);
      else dropped = 1'b1;
    end
    if (!last) return;
    while (kept.size() > 0 && left > 0) begin
      void'(kept.pop_back());
      left--;
    end
    if (kept.size() == 0) begin
      r.digit = sdkr_pkg::DIGIT_ZERO;
      r.last  = 1'b1;
      r.ovf   = dropped;
      due.push_back(r);
    end else begin
      for (int i = 0; i < kept.size(); i++) begin
        r.digit = kept[i];
        r.last  = (i == kept.size() - 1);
        r.ovf   = dropped;
        due.push_back(r);
      end
    end
    fresh = 1'b1;
  endfunction

  function void check_digit(input logic [sdkr_pkg::DIGIT_W-1:0] digit, input logic last,
                            input logic ovf);
    result_digit_t r;
    if (due.size() == 0) begin
      $display("%0t: unexpected result digit %0d last %0b overflowed %0b",
               $time, digit, last, ovf);
      errors++;
      return;
    end
    r = due.pop_front();
    if (r.digit !== digit) begin
      $display("%0t: out_digit expected %0d actual %0d", $time, r.digit, digit);
      errors++;
    end
    if (r.last !== last) begin
      $display("%0t: out_last expected %0b actual %0b", $time, r.last, last);
      errors++;
    end
    if (r.ovf !== ovf) begin
      $display("%0t: overflowed expected %0b actual %0b", $time, r.ovf, ovf);
      errors++;
    end
  endfunction
endclass

module testbench;
  import sdkr_pkg::*;

  localparam int RANDOM_DIGITS = 270;
  localparam int DIRECTED      = 25;
  // drain of the longest result plus alignment shifts, with margin
  localparam int SETTLE_CYCLES = 3 * MAX_DIGITS + 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 2000000;

  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [TDATA_W-1:0]   in_tdata   = '0;   // [3:0] digit, rest zero
  logic                 in_tlast   = 1'b0; // last_digit
  logic                 out_tready = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [REM_W-1:0]     cfg_data   = '0;   // removals
  logic                 in_tready;
  logic                 out_tvalid;
  logic [TDATA_W-1:0]   out_tdata;         // [3:0] out_digit
  logic                 out_tlast;         // out_last
  logic                 out_tuser;         // overflowed
  logic                 cfg_ready;

  trimmed_number_board board;

  int burst_left      = 0;   // transactions left in the current sender burst
  int gap_max         = 0;   // 0 = sender never idles
  int digits_sent     = 0;
  int holds_requested = 0;   // bumped by stimulus, served by the receiver

  smallest_digits_after_k_removals_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

  // Receiver: ready pattern changes mode every so often. On request it
  // holds off for a long stretch so the result path backs up into the input.
  initial begin : receiver
    rx_mode_t    mode;
    int          mode_left;
    int          holds_served;
    logic [7:0]  pat;
    logic        rdy;
    mode         = RX_ALWAYS;
    mode_left    = 0;
    holds_served = 0;
    pat          = 8'hff;
    forever begin
      @(posedge clk);
      if (holds_served != holds_requested) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
        pat       = 8'($urandom);
      end
      mode_left--;
      case (mode)
        RX_ALWAYS: rdy = 1'b1;
        RX_COIN:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
        default: begin
          rdy = pat[0];
          pat = {pat[0], pat[7:1]};
        end
      endcase
      out_tready <= rdy;
    end
  end

  // Result monitor: every output transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_digit(out_tdata[DIGIT_W-1:0], out_tlast, out_tuser);
  end

  // One input transaction. Valid stays up between back-to-back digits;
  // a gap is only opened at the start of a new burst.
  task automatic send_digit(input logic [DIGIT_W-1:0] d, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_W-DIGIT_W){1'b0}}, d};
    in_tlast  <= last;
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    burst_left--;
    digits_sent++;
    board.note_digit(d, last);
  endtask

  // Directed numbers written as text; A..F give the out-of-range digits.
  task automatic send_text(input string s);
    logic [DIGIT_W-1:0] d;
    for (int i = 0; i < s.len(); i++) begin
      d = (s[i] >= "A") ? DIGIT_W'(s[i] - "A" + 10) : DIGIT_W'(s[i] - "0");
      send_digit(d, i == s.len() - 1);
    end
  endtask

  // Mostly 0..9, some extra zeros for leading-zero runs, a few above nine.
  task automatic send_random_number(input int len);
    int                 roll;
    logic [DIGIT_W-1:0] d;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) d = DIGIT_W'($urandom_range(10, 15));
      else if (roll < 3) d = DIGIT_ZERO;
      else d = DIGIT_W'($urandom_range(0, 9));
      send_digit(d, i == len - 1);
    end
  endtask

  // Stop offering, wait for all results, then let the block go quiet.
  task automatic wait_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_removals(input logic [REM_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_removals(v);
  endtask

  initial begin : stimulus
    int len;
    int nums;
    int phase;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // removals still at reset value 0
    send_text("AF09");      // digits above nine saturate
    send_text("003");       // leading zeros never land on the stack
    send_text("0");         // empty stack -> single 0
    wait_drained();
    write_removals(7'd2);
    send_text("1432219");
    send_text("56");        // everything removed
    wait_drained();
    write_removals(7'd64);
    send_text("738");       // more removals than digits
    wait_drained();
    write_removals(7'd127);
    send_text("9");
    wait_drained();
    write_removals(7'd1);
    send_text("1002");      // pop exposes zeros that become leading

    // Random phases, one removals setting each; phases 0 and 3 of each
    // cycle open with a number long enough to fill the stack.
    phase = 0;
    while (digits_sent < DIRECTED + RANDOM_DIGITS) begin
      wait_drained();
      case (phase % 6)
        0:       write_removals(7'd0);
        1:       write_removals(7'd64);
        2:       write_removals(7'd127);
        3:       write_removals(REM_W'($urandom_range(1, 4)));
        4:       write_removals(REM_W'($urandom_range(5, 20)));
        default: write_removals(REM_W'($urandom_range(0, 127)));
      endcase
      gap_max = (phase % 3 == 1) ? 0 : $urandom_range(2, 16);
      nums = $urandom_range(4, 8);
      for (int n = 0; n < nums; n++) begin
        // long result still draining -> stalled receiver backs up the input
        if (n == 1 && phase == 3) holds_requested++;
        if (n == 0 && (phase % 6 == 0 || phase % 6 == 3)) len = $urandom_range(65, 72);
        else if ($urandom_range(0, 3) == 0) len = $urandom_range(17, 40);
        else len = $urandom_range(1, 16);
        send_random_number(len);
      end
      phase++;
    end

    wait_drained();
    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sdkr_pkg.sv
rtl/sdkr_cell.sv
rtl/sdkr_stack.sv
rtl/smallest_digits_after_k_removals_core.sv
tb/testbench.sv
